>>> rtl/core/hre_pkg.sv
package hre_pkg;

    localparam int H_W    = 48;
    localparam int PT_W   = 32;
    localparam int NUM_H  = 8;
    localparam int IDX_W  = 3;
    localparam int ACC_W  = 82;            // signed numerator / denominator
    localparam int MAG_W  = 81;            // magnitude of an ACC_W value
    localparam int QM_W   = 47;            // saturated quotient magnitude
    localparam int DM_W   = 49;            // |dx|, |dy|
    localparam int SUM_W  = 48;

    localparam logic [IDX_W-1:0] CFG_H11 = 3'd0;
    localparam logic [IDX_W-1:0] CFG_H12 = 3'd1;
    localparam logic [IDX_W-1:0] CFG_H13 = 3'd2;
    localparam logic [IDX_W-1:0] CFG_H21 = 3'd3;
    localparam logic [IDX_W-1:0] CFG_H22 = 3'd4;
    localparam logic [IDX_W-1:0] CFG_H23 = 3'd5;
    localparam logic [IDX_W-1:0] CFG_H31 = 3'd6;
    localparam logic [IDX_W-1:0] CFG_H32 = 3'd7;

    localparam logic [H_W-1:0] H_ONE = 48'h0001_0000_0000;   // 1.0 in Q15.32

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIVX,
        S_DIVY,
        S_DIST,
        S_ACC
    } state_t;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] n;
        n = -v;
        return v[ACC_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

endpackage

>>> rtl/core/hre_div.sv
module hre_div
    import hre_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MAG_W-1:0] num,
    input  logic [MAG_W-1:0] den,
    output logic             done,
    output logic [QM_W-1:0]  quot
);

    localparam int REM_W = MAG_W + 2;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             sat_reg, sat_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [47:0]      low_reg, low_next;
    logic [47:0]      q_reg, q_next;
    logic [MAG_W-1:0] den_reg, den_next;
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] den_ext;
    logic             qbit;

    always_comb
    begin
        shifted   = {rem_reg[REM_W-2:0], low_reg[47]};
        den_ext   = {2'b00, den_reg};
        qbit      = (shifted >= den_ext);
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (start)
        begin
            // quotient of at least 2^48 if the top part already reaches the divisor
            rem_next  = {{(REM_W-49){1'b0}}, num[MAG_W-1:32]};
            low_next  = {num[31:0], 16'h0000};
            q_next    = '0;
            sat_next  = ({{(MAG_W-49){1'b0}}, num[MAG_W-1:32]} >= den);
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? (shifted - den_ext) : shifted;
            low_next = {low_reg[46:0], 1'b0};
            q_next   = {q_reg[46:0], qbit};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg <= sat_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = (sat_reg || q_reg[47]) ? {QM_W{1'b1}} : q_reg[QM_W-1:0];

endmodule

>>> rtl/core/hre_dist.sv
module hre_dist
    import hre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DM_W-1:0]   adx,
    input  logic [DM_W-1:0]   ady,
    output logic              done,
    output logic [SUM_W-1:0]  distance
);

    localparam int SQ_W   = 2 * DM_W;
    localparam int SREM_W = DM_W + 3;

    logic              busy_reg, busy_next;
    logic              root_ph_reg, root_ph_next;
    logic              done_reg, done_next;
    logic              sel_reg, sel_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [DM_W-1:0]   adx_reg, adx_next;
    logic [DM_W-1:0]   ady_reg, ady_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [SREM_W-1:0] rem_reg, rem_next;
    logic [DM_W-1:0]   root_reg, root_next;
    logic [DM_W-1:0]   a_op;
    logic [55:0]       a_pad;
    logic [7:0]        chunk;
    logic [DM_W+7:0]   prod;
    logic [SQ_W+7:0]   term;
    logic [SREM_W-1:0] rem_sh;
    logic [SREM_W-1:0] trial;

    always_comb
    begin
        a_op   = sel_reg ? ady_reg : adx_reg;
        a_pad  = {{(56-DM_W){1'b0}}, a_op};
        chunk  = 8'(a_pad >> {cnt_reg[2:0], 3'b000});
        prod   = a_op * chunk;
        term   = {{(SQ_W-DM_W){1'b0}}, prod} << {cnt_reg[2:0], 3'b000};
        rem_sh = {rem_reg[SREM_W-3:0], sq_reg[SQ_W-1:SQ_W-2]};
        trial  = {1'b0, root_reg, 2'b01};

        busy_next    = busy_reg;
        root_ph_next = root_ph_reg;
        done_next    = 1'b0;
        sel_next     = sel_reg;
        cnt_next     = cnt_reg;
        adx_next     = adx_reg;
        ady_next     = ady_reg;
        sq_next      = sq_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        if (start)
        begin
            adx_next     = adx;
            ady_next     = ady;
            sq_next      = '0;
            sel_next     = 1'b0;
            cnt_next     = '0;
            root_ph_next = 1'b0;
            busy_next    = 1'b1;
        end
        else if (busy_reg && !root_ph_reg)
        begin
            // squares, one byte of the multiplier a cycle
            sq_next  = sq_reg + term[SQ_W-1:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd6)
            begin
                cnt_next = '0;
                sel_next = 1'b1;
                if (sel_reg)
                begin
                    root_ph_next = 1'b1;
                    rem_next     = '0;
                    root_next    = '0;
                end
            end
        end
        else if (busy_reg)
        begin
            // restoring square root, one result bit a cycle
            sq_next  = {sq_reg[SQ_W-3:0], 2'b00};
            cnt_next = cnt_reg + 6'd1;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[DM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[DM_W-2:0], 1'b0};
            end
            if (cnt_reg == 6'(DM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            root_ph_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            root_ph_reg <= root_ph_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg  <= sel_next;
        cnt_reg  <= cnt_next;
        adx_reg  <= adx_next;
        ady_reg  <= ady_next;
        sq_reg   <= sq_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done     = done_reg;
    assign distance = root_reg[DM_W-1] ? {SUM_W{1'b1}} : root_reg[SUM_W-1:0];

endmodule

>>> rtl/core/homography_reprojection_error.sv
// Per pair: a 48x9 multiply-accumulate, one quotient each for x and y on the shared
// divider, the distance unit, then the accumulate; a pair with zero denominator
// skips the divider and the distance unit.
// A new pair is taken only once the previous one is finished; s_tready is high only
// between pairs, and a last pair also waits while the previous total is unaccepted.
// Reset clears the sum, the flag and the output valid, and loads H with the identity.
module homography_reprojection_error
    import hre_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [127:0]       s_tdata,   // img_x, img_y, obj_x, obj_y
    input  logic               s_tlast,   // last_pair
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,   // total_error
    output logic               m_tuser,   // degenerate
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [H_W-1:0]     cfg_data
);

    state_t state_reg, state_next;

    logic [H_W-1:0]           h_reg [NUM_H];
    logic [4:0]               mcnt_reg, mcnt_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  w_reg, w_next;
    logic signed [ACC_W-1:0]  x_reg, x_next;
    logic signed [ACC_W-1:0]  y_reg, y_next;
    logic signed [PT_W-1:0]   ix_reg, ix_next, iy_reg, iy_next;
    logic signed [PT_W-1:0]   ox_reg, ox_next, oy_reg, oy_next;
    logic                     last_reg, last_next;
    logic signed [QM_W+1:0]   px_reg, px_next;
    logic [SUM_W-1:0]         dist_reg, dist_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic                     deg_reg, deg_next;
    logic [SUM_W-1:0]         out_data_reg, out_data_next;
    logic                     out_deg_reg, out_deg_next;
    logic                     out_valid_reg, out_valid_next;

    logic [2:0]               p;
    logic [1:0]               k;
    logic signed [H_W-1:0]    h_op;
    logic signed [PT_W-1:0]   o_op;
    logic [7:0]               chunk;
    logic signed [8:0]        chunk9;
    logic signed [H_W+8:0]    prod;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  mac_sum;

    logic                     div_start, div_done;
    logic [MAG_W-1:0]         div_num, den_mag;
    logic [QM_W-1:0]          quot;
    logic signed [QM_W+1:0]   q_signed;
    logic                     dist_start, dist_done;
    logic [SUM_W-1:0]         distance;
    logic signed [DM_W:0]     dx, dy;
    logic [DM_W-1:0]          adx, ady;
    logic [SUM_W:0]           sum_wide;
    logic [SUM_W-1:0]         sum_sat;
    logic                     w_zero;

    hre_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_mag),
        .done  (div_done),
        .quot  (quot)
    );

    hre_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dist_start),
        .adx      (adx),
        .ady      (ady),
        .done     (dist_done),
        .distance (distance)
    );

    // term order: h31*ox, h32*oy, h11*ox, h12*oy, h21*ox, h22*oy
    always_comb
    begin
        p = mcnt_reg[4:2];
        k = mcnt_reg[1:0];
        case (p)
            3'd0:    h_op = h_reg[CFG_H31];
            3'd1:    h_op = h_reg[CFG_H32];
            3'd2:    h_op = h_reg[CFG_H11];
            3'd3:    h_op = h_reg[CFG_H12];
            3'd4:    h_op = h_reg[CFG_H21];
            3'd5:    h_op = h_reg[CFG_H22];
            default: h_op = h_reg[CFG_H31];
        endcase
        o_op   = p[0] ? oy_reg : ox_reg;
        chunk  = 8'(o_op >> {k, 3'b000});
        chunk9 = (k == 2'd3) ? {chunk[7], chunk} : {1'b0, chunk};
        prod   = h_op * chunk9;
        term   = {{(ACC_W-H_W-9){prod[H_W+8]}}, prod} <<< {k, 3'b000};
        if (!p[0] && k == 2'd0)
        begin
            case (p[2:1])
                2'd0:    base = ACC_W'(82'sd1 <<< 48);
                2'd1:    base = {{(ACC_W-H_W-16){h_reg[CFG_H13][H_W-1]}},
                                 h_reg[CFG_H13], 16'h0000};
                default: base = {{(ACC_W-H_W-16){h_reg[CFG_H23][H_W-1]}},
                                 h_reg[CFG_H23], 16'h0000};
            endcase
        end
        else
        begin
            base = acc_reg;
        end
        mac_sum = base + term;
    end

    assign w_zero   = (w_reg == '0);
    assign den_mag  = mag_of(w_reg);
    assign sum_wide = {1'b0, sum_reg} + {1'b0, dist_reg};
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        mcnt_next      = mcnt_reg;
        acc_next       = acc_reg;
        w_next         = w_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        ix_next        = ix_reg;
        iy_next        = iy_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        last_next      = last_reg;
        px_next        = px_reg;
        dist_next      = dist_reg;
        sum_next       = sum_reg;
        deg_next       = deg_reg;
        out_data_next  = out_data_reg;
        out_deg_next   = out_deg_reg;
        out_valid_next = out_valid_reg && !m_tready;
        div_start      = 1'b0;
        div_num        = mag_of(x_reg);
        dist_start     = 1'b0;
        q_signed       = '0;
        dx             = '0;
        dy             = '0;
        adx            = '0;
        ady            = '0;
        s_tready       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ix_next    = s_tdata[31:0];
                    iy_next    = s_tdata[63:32];
                    ox_next    = s_tdata[95:64];
                    oy_next    = s_tdata[127:96];
                    last_next  = s_tlast;
                    mcnt_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next  = mac_sum;
                mcnt_next = mcnt_reg + 5'd1;
                if (p[0] && k == 2'd3)
                begin
                    case (p[2:1])
                        2'd0:    w_next = mac_sum;
                        2'd1:    x_next = mac_sum;
                        default: y_next = mac_sum;
                    endcase
                end
                if (mcnt_reg == 5'd23)
                begin
                    if (w_zero)
                    begin
                        state_next = S_ACC;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIVX;
                    end
                end
            end
            S_DIVX:
            begin
                q_signed = {2'b00, quot};
                if (div_done)
                begin
                    px_next    = (x_reg[ACC_W-1] ^ w_reg[ACC_W-1]) ? -q_signed : q_signed;
                    div_num    = mag_of(y_reg);
                    div_start  = 1'b1;
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                q_signed = {2'b00, quot};
                if (y_reg[ACC_W-1] ^ w_reg[ACC_W-1])
                begin
                    q_signed = -q_signed;
                end
                dx  = {{(DM_W-PT_W+1){ix_reg[PT_W-1]}}, ix_reg}
                      - {px_reg[QM_W+1], px_reg};
                dy  = {{(DM_W-PT_W+1){iy_reg[PT_W-1]}}, iy_reg}
                      - {q_signed[QM_W+1], q_signed};
                adx = dx[DM_W] ? DM_W'(-dx) : dx[DM_W-1:0];
                ady = dy[DM_W] ? DM_W'(-dy) : dy[DM_W-1:0];
                if (div_done)
                begin
                    dist_start = 1'b1;
                    state_next = S_DIST;
                end
            end
            S_DIST:
            begin
                if (dist_done)
                begin
                    dist_next  = distance;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (!last_reg)
                begin
                    sum_next   = w_zero ? sum_reg : sum_sat;
                    deg_next   = deg_reg | w_zero;
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = w_zero ? sum_reg : sum_sat;
                    out_deg_next   = deg_reg | w_zero;
                    out_valid_next = 1'b1;
                    sum_next       = '0;
                    deg_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            deg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            deg_reg       <= deg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_H; i++)
            begin
                h_reg[i] <= '0;
            end
            h_reg[CFG_H11] <= H_ONE;
            h_reg[CFG_H22] <= H_ONE;
        end
        else if (cfg_we)
        begin
            h_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        mcnt_reg     <= mcnt_next;
        acc_reg      <= acc_next;
        w_reg        <= w_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        ix_reg       <= ix_next;
        iy_reg       <= iy_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        last_reg     <= last_next;
        px_reg       <= px_next;
        dist_reg     <= dist_next;
        out_data_reg <= out_data_next;
        out_deg_reg  <= out_deg_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_deg_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again straight after a transfer");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVX || state_reg == S_DIVY))
        else $error("divider finished outside a divide state");

    a_dist_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        dist_done |-> state_reg == S_DIST)
        else $error("distance unit finished outside its state");

    a_out_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(last_reg))
        else $error("result raised for a pair not marked last");
`endif

endmodule
